// ===== hw/rtl/grid_bilinear_interpolator_unit_defines.svh =====
// Assertion macros used by the checker file of the grid interpolator.
`ifndef GRID_BILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gbi_pkg.sv =====
// Shared constants, codes and control structures of the grid interpolator.
package gbi_pkg;

   localparam int MAX_HEIGHTS_DEF = 64;
   localparam int MAX_ANGLES_DEF  = 64;

   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 32;
   localparam int COUNT_W     = 7;
   localparam int VALUE_W     = 32;
   localparam int SLOT_W      = 6;
   localparam int WEIGHT_W    = 17;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   localparam logic [1:0] CMD_WR_HEIGHT  = 2'd0;
   localparam logic [1:0] CMD_WR_ANGLE   = 2'd1;
   localparam logic [1:0] CMD_WR_PROFILE = 2'd2;
   localparam logic [1:0] CMD_QUERY      = 2'd3;

   localparam logic CSR_HEIGHT_COUNT = 1'b0;
   localparam logic CSR_ANGLE_COUNT  = 1'b1;

   localparam logic AXIS_ANGLE  = 1'b0;
   localparam logic AXIS_HEIGHT = 1'b1;

   localparam logic [1:0] TERM_LAST = 2'd3;

   typedef struct packed {
      logic       store;
      logic       capture;
      logic       scan_init;
      logic       scan_en;
      logic       div_en;
      logic       axis;
      logic       mac_rd;
      logic       mac_mul;
      logic       mac_acc;
      logic       out_load;
      logic [1:0] term;
   } ctl_type;

   typedef struct packed {
      logic scan_done;
      logic at_end;
      logic div_done;
   } sts_type;

endpackage

// ===== hw/rtl/gbi_ctrl.sv =====
// Sequencing state machine: load command acceptance and the scan, divide and accumulate steps of one query.
module gbi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output gbi_pkg::ctl_type ctl,
   input  gbi_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SCAN = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_RD   = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_ACC  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       axis_ff, axis_in;
   logic [1:0] term_ff, term_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      term_in       = term_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      ctl           = '0;
      ctl.axis      = axis_ff;
      ctl.term      = term_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.store = 1'b1;
               if (req_cmd == gbi_pkg::CMD_QUERY) begin
                  ctl.capture   = 1'b1;
                  ctl.scan_init = 1'b1;
                  axis_in       = gbi_pkg::AXIS_ANGLE;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ctl.scan_en = 1'b1;
            if (sts.scan_done) begin
               if (!sts.at_end) begin
                  state_in = S_DIV;
               end else if (axis_ff == gbi_pkg::AXIS_ANGLE) begin
                  axis_in       = gbi_pkg::AXIS_HEIGHT;
                  ctl.scan_init = 1'b1;
               end else begin
                  term_in  = '0;
                  state_in = S_RD;
               end
            end
         end
         S_DIV: begin
            ctl.div_en = 1'b1;
            if (sts.div_done) begin
               if (axis_ff == gbi_pkg::AXIS_ANGLE) begin
                  axis_in       = gbi_pkg::AXIS_HEIGHT;
                  ctl.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  term_in  = '0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            ctl.mac_rd = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            ctl.mac_mul = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            ctl.mac_acc = 1'b1;
            if (term_ff == gbi_pkg::TERM_LAST) begin
               state_in = S_FIN;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               ctl.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         axis_ff       <= gbi_pkg::AXIS_ANGLE;
         term_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         term_ff       <= term_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

// ===== hw/rtl/gbi_datapath.sv =====
// Axis and profile memories, axis scan, weight divider and accumulator.
module gbi_datapath #(
   parameter int MAX_HEIGHTS = gbi_pkg::MAX_HEIGHTS_DEF,
   parameter int MAX_ANGLES  = gbi_pkg::MAX_ANGLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic                               csr_index,
   input  logic [gbi_pkg::COUNT_W-1:0]        csr_wdata,
   input  logic [1:0]                         req_cmd,
   input  logic [gbi_pkg::SLOT_W-1:0]         req_height_slot,
   input  logic [gbi_pkg::SLOT_W-1:0]         req_angle_slot,
   input  logic [gbi_pkg::VALUE_W-1:0]        req_write_value,
   input  logic [gbi_pkg::VALUE_W-1:0]        req_query_angle,
   input  logic [gbi_pkg::VALUE_W-1:0]        req_query_height,
   output logic [gbi_pkg::VALUE_W-1:0]        rsp_interp_value,
   input  gbi_pkg::ctl_type                   ctl,
   output gbi_pkg::sts_type                   sts
);

   localparam int HW   = $clog2(MAX_HEIGHTS);
   localparam int AW   = $clog2(MAX_ANGLES);
   localparam int PD   = MAX_HEIGHTS * MAX_ANGLES;
   localparam int PAW  = $clog2(PD);
   localparam int MAXD = (MAX_HEIGHTS > MAX_ANGLES) ? MAX_HEIGHTS : MAX_ANGLES;
   localparam int IXW  = $clog2(MAXD + 1);
   localparam int VW   = gbi_pkg::VALUE_W;
   localparam int WW   = gbi_pkg::WEIGHT_W;

   logic [VW-1:0] height_axis [MAX_HEIGHTS];
   logic [VW-1:0] angle_axis  [MAX_ANGLES];
   logic [VW-1:0] profile_mem [PD];

   logic [gbi_pkg::COUNT_W-1:0] height_count_ff, angle_count_ff;
   logic [IXW-1:0] n_h, n_a, n_sel;

   logic signed [VW-1:0] qa_ff, qh_ff, x_sel;
   logic signed [VW-1:0] ard_ff, hrd_ff, rd_sel, prev_ff;
   logic [IXW-1:0] iss_ff, chk_ff;
   logic           chk_vld_ff;
   logic           found, last;

   logic [AW-1:0] ai0_ff, ai1_ff;
   logic [HW-1:0] hi0_ff, hi1_ff;
   logic [WW-1:0] aw0_ff, aw1_ff, hw0_ff, hw1_ff;
   logic [IXW-1:0] idx_lo, idx_hi;
   logic [WW-1:0]  w_lo;

   logic [33:0] rem_ff, rem_sub;
   logic [32:0] den_ff;
   logic [WW-2:0] quo_ff;
   logic [4:0]    dcnt_ff;
   logic          ge;
   logic [WW-1:0] q_final;
   logic signed [32:0] num_diff, den_diff;

   logic [AW-1:0]  a_pick;
   logic [HW-1:0]  h_pick;
   logic [WW-1:0]  aw_pick, hw_pick;
   logic [PAW-1:0] paddr, waddr;
   logic signed [VW-1:0] prd_ff;
   logic [32:0]    w_ff;
   logic signed [65:0] prod_ff, acc_ff;
   logic [33:0]    q_res;
   logic [VW-1:0]  rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_count_ff <= gbi_pkg::COUNT_W'(1);
         angle_count_ff  <= gbi_pkg::COUNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gbi_pkg::CSR_HEIGHT_COUNT: height_count_ff <= csr_wdata;
            gbi_pkg::CSR_ANGLE_COUNT:  angle_count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (height_count_ff == '0) begin
         n_h = IXW'(1);
      end else if (int'(height_count_ff) > MAX_HEIGHTS) begin
         n_h = IXW'(MAX_HEIGHTS);
      end else begin
         n_h = IXW'(height_count_ff);
      end
      if (angle_count_ff == '0) begin
         n_a = IXW'(1);
      end else if (int'(angle_count_ff) > MAX_ANGLES) begin
         n_a = IXW'(MAX_ANGLES);
      end else begin
         n_a = IXW'(angle_count_ff);
      end
   end

   // Memory writes and axis reads.
   assign waddr = PAW'(PAW'(HW'(req_height_slot)) * PAW'(MAX_ANGLES) + PAW'(AW'(req_angle_slot)));

   always_ff @(posedge clock) begin
      if (ctl.store && req_cmd == gbi_pkg::CMD_WR_HEIGHT &&
          int'(req_height_slot) < MAX_HEIGHTS) begin
         height_axis[HW'(req_height_slot)] <= req_write_value;
      end
      if (ctl.store && req_cmd == gbi_pkg::CMD_WR_ANGLE &&
          int'(req_angle_slot) < MAX_ANGLES) begin
         angle_axis[AW'(req_angle_slot)] <= req_write_value;
      end
      ard_ff <= angle_axis[iss_ff[AW-1:0]];
      hrd_ff <= height_axis[iss_ff[HW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.store && req_cmd == gbi_pkg::CMD_WR_PROFILE &&
          int'(req_height_slot) < MAX_HEIGHTS && int'(req_angle_slot) < MAX_ANGLES) begin
         profile_mem[waddr] <= req_write_value;
      end
      if (ctl.mac_rd) begin
         prd_ff <= profile_mem[paddr];
      end
   end

   // Axis scan for the first entry above the coordinate.
   assign x_sel  = (ctl.axis == gbi_pkg::AXIS_HEIGHT) ? qh_ff : qa_ff;
   assign rd_sel = (ctl.axis == gbi_pkg::AXIS_HEIGHT) ? hrd_ff : ard_ff;
   assign n_sel  = (ctl.axis == gbi_pkg::AXIS_HEIGHT) ? n_h : n_a;
   assign found  = chk_vld_ff && (rd_sel > x_sel);
   assign last   = chk_vld_ff && (chk_ff + IXW'(1) == n_sel);

   assign sts.scan_done = ctl.scan_en && (found || last);
   assign sts.at_end    = found ? (chk_ff == '0) : 1'b1;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         qa_ff <= req_query_angle;
         qh_ff <= req_query_height;
      end
      if (ctl.scan_init) begin
         iss_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else if (ctl.scan_en) begin
         iss_ff     <= iss_ff + IXW'(1);
         chk_ff     <= iss_ff;
         chk_vld_ff <= 1'b1;
         if (chk_vld_ff) begin
            prev_ff <= rd_sel;
         end
      end
   end

   // Indices and weights at the end of a scan.
   always_comb begin
      if (!sts.at_end) begin
         idx_lo = chk_ff - IXW'(1);
         idx_hi = chk_ff;
      end else begin
         idx_lo = found ? '0 : n_sel - IXW'(1);
         idx_hi = '0;
      end
      w_lo = (ctl.axis == gbi_pkg::AXIS_ANGLE) ? gbi_pkg::WEIGHT_ONE : '0;
   end

   // Restoring divider for the low weight, one quotient bit a cycle.
   assign num_diff = {rd_sel[VW-1], rd_sel} - {x_sel[VW-1], x_sel};
   assign den_diff = {rd_sel[VW-1], rd_sel} - {prev_ff[VW-1], prev_ff};
   assign ge       = (rem_ff >= {1'b0, den_ff});
   assign rem_sub  = rem_ff - (ge ? {1'b0, den_ff} : 34'd0);
   assign q_final  = {quo_ff, ge};
   assign sts.div_done = ctl.div_en && (dcnt_ff == 5'd16);

   always_ff @(posedge clock) begin
      if (sts.scan_done && !sts.at_end) begin
         rem_ff  <= {1'b0, num_diff};
         den_ff  <= den_diff;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (ctl.div_en) begin
         rem_ff  <= {rem_sub[32:0], 1'b0};
         quo_ff  <= q_final[WW-2:0];
         dcnt_ff <= dcnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (sts.scan_done) begin
         if (ctl.axis == gbi_pkg::AXIS_ANGLE) begin
            ai0_ff <= AW'(idx_lo);
            ai1_ff <= AW'(idx_hi);
            if (sts.at_end) begin
               aw0_ff <= w_lo;
               aw1_ff <= '0;
            end
         end else begin
            hi0_ff <= HW'(idx_lo);
            hi1_ff <= HW'(idx_hi);
            if (sts.at_end) begin
               hw0_ff <= w_lo;
               hw1_ff <= '0;
            end
         end
      end else if (sts.div_done) begin
         if (ctl.axis == gbi_pkg::AXIS_ANGLE) begin
            aw0_ff <= q_final;
            aw1_ff <= gbi_pkg::WEIGHT_ONE - q_final;
         end else begin
            hw0_ff <= q_final;
            hw1_ff <= gbi_pkg::WEIGHT_ONE - q_final;
         end
      end
   end

   // Weighted sum: term index bit 1 picks the angle entry, bit 0 the height entry.
   assign a_pick  = ctl.term[1] ? ai1_ff : ai0_ff;
   assign aw_pick = ctl.term[1] ? aw1_ff : aw0_ff;
   assign h_pick  = ctl.term[0] ? hi1_ff : hi0_ff;
   assign hw_pick = ctl.term[0] ? hw1_ff : hw0_ff;
   assign paddr   = PAW'(PAW'(h_pick) * PAW'(MAX_ANGLES) + PAW'(a_pick));

   always_ff @(posedge clock) begin
      if (ctl.mac_rd) begin
         w_ff <= 33'(hw_pick * aw_pick);
      end
      if (ctl.mac_mul) begin
         prod_ff <= prd_ff * $signed({1'b0, w_ff});
      end
      if (ctl.capture) begin
         acc_ff <= '0;
      end else if (ctl.mac_acc) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Truncation toward zero of the sum scaled down by 2^32.
   assign q_res = acc_ff[65:32] + {33'd0, acc_ff[65] && (acc_ff[31:0] != '0)};

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_data_ff <= q_res[VW-1:0];
      end
   end

   assign rsp_interp_value = rsp_data_ff;

endmodule

// ===== hw/rtl/grid_bilinear_interpolator_unit.sv =====
// Top level of the grid bilinear interpolator.
//
//   Channel   Direction  Transfer condition         Contents
//   req_*     in         req_tvalid && req_tready   load command or query
//   rsp_*     out        rsp_tvalid && rsp_tready   interpolated value
//   csr_*     in         csr_wr_en                  axis entry counts
//
// A load command is written in its transfer cycle. A query holds req_tready low until
// its result goes into the output register. It runs a linear scan of the registered axis
// memory on each axis, a divider per interior axis and four multiply-accumulate steps,
// each with a read, a multiply and an accumulate state. An axis whose coordinate lies
// outside its table skips its divider. Reset is synchronous and clears the control state
// and sets both counts to one. A finished result waits in the output register while new
// load commands are taken; a later query waits in its final state until that result is taken.
module grid_bilinear_interpolator_unit #(
   parameter int MAX_HEIGHTS = gbi_pkg::MAX_HEIGHTS_DEF,
   parameter int MAX_ANGLES  = gbi_pkg::MAX_ANGLES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cmd, height_slot, angle_slot, write_value, query_angle, query_height, pad
   input  logic [gbi_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // interp_value
   output logic [gbi_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic                               csr_index,
   input  logic [gbi_pkg::COUNT_W-1:0]        csr_wdata
);

   gbi_pkg::ctl_type ctl;
   gbi_pkg::sts_type sts;

   gbi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tdata[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .sts        (sts)
   );

   gbi_datapath #(
      .MAX_HEIGHTS (MAX_HEIGHTS),
      .MAX_ANGLES  (MAX_ANGLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_tdata[1:0]),
      .req_height_slot  (req_tdata[7:2]),
      .req_angle_slot   (req_tdata[13:8]),
      .req_write_value  (req_tdata[45:14]),
      .req_query_angle  (req_tdata[77:46]),
      .req_query_height (req_tdata[109:78]),
      .rsp_interp_value (rsp_tdata),
      .ctl              (ctl),
      .sts              (sts)
   );

endmodule

// ===== hw/rtl/gbi_checker.sv =====
// Port-level checks of the grid interpolator and their binding to the top level.
`include "grid_bilinear_interpolator_unit_defines.svh"

module gbi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gbi_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gbi_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic req_xfer;
   logic rsp_wait;
   logic is_query;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign is_query = (req_tdata[1:0] == gbi_pkg::CMD_QUERY);

   `GBI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid, "rsp dropped")
   `GBI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_wait, $stable(rsp_tdata), "rsp data changed")
   `GBI_ASSERT_NEXT(a_query_busy, clock, reset, req_xfer && is_query, !req_tready, "ready after query")
   `GBI_ASSERT_NEXT(a_write_silent, clock, reset, req_xfer && !is_query && !rsp_tvalid, !rsp_tvalid, "load rsp")

endmodule

bind grid_bilinear_interpolator_unit gbi_checker u_gbi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
